// File: sv/set_assoc_lru_cache_model_core_defines.svh
// Assertion macros used by the checker file.
`ifndef SET_ASSOC_LRU_CACHE_MODEL_CORE_DEFINES_SVH
`define SET_ASSOC_LRU_CACHE_MODEL_CORE_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define SALC_ASSERT_IMPL(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);
// Next-cycle implication checked outside reset.
`define SALC_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);
`endif

// File: sv/salc_pkg.sv
// Shared types and constants for the set-associative LRU cache tag store.
package salc_pkg;
    localparam int MAX_SET_BITS = 6;
    localparam int MAX_WAYS     = 8;
    localparam int ADDR_WIDTH   = 64;

    localparam logic [1:0] MODE_LOAD   = 2'd0;
    localparam logic [1:0] MODE_STORE  = 2'd1;
    localparam logic [1:0] MODE_MODIFY = 2'd2;

    localparam logic [1:0] OUT_HIT   = 2'd0;
    localparam logic [1:0] OUT_FILL  = 2'd1;
    localparam logic [1:0] OUT_EVICT = 2'd2;

    localparam logic [1:0] CFG_SET_BITS    = 2'd0;
    localparam logic [1:0] CFG_OFFSET_BITS = 2'd1;
    localparam logic [1:0] CFG_WAYS_IN_USE = 2'd2;

    typedef struct packed {
        logic [1:0]  mode;
        logic [63:0] address;
    } t_in_word;

    typedef struct packed {
        logic [1:0]  outcome;
        logic        second_hit;
        logic [31:0] hits_total;
        logic [31:0] misses_total;
        logic [31:0] evictions_total;
    } t_out_word;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_LOOK1,
        ST_LOOK2,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic clear;
        logic load_in;
        logic access;
        logic second;
        logic load_out;
    } t_ctrl;

    typedef struct packed {
        logic modify;
        logic clear_last;
    } t_stat;
endpackage

// File: sv/set_assoc_lru_cache_model_core.sv
// Top level of the set-associative LRU cache tag store.
// After reset the tag store runs a clearing pass over all 2^MAX_SET_BITS sets (64 by
// default) with the input not ready. A load or store word, once accepted, passes
// through a step that reads the set's row, one that compares the ways in use and
// writes the row back, and one that loads the output register; a modify adds its
// second access before the output load. One word is in flight at a time and the next
// can be accepted the cycle after the result is loaded, so no new word is taken before
// the last one's result is loaded, which a stalled output delays.
// Config is taken in any cycle and must be written only with no word in flight.
module set_assoc_lru_cache_model_core #(
    parameter int MAX_SET_BITS = salc_pkg::MAX_SET_BITS,
    parameter int MAX_WAYS     = salc_pkg::MAX_WAYS,
    parameter int ADDR_WIDTH   = salc_pkg::ADDR_WIDTH
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [1:0]           i_cfg_index,
    input  logic [5:0]           i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  salc_pkg::t_in_word   i_in_word,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output salc_pkg::t_out_word  o_out_word
);
    salc_pkg::t_ctrl ctrl;
    salc_pkg::t_stat stat;

    assign o_cfg_ready = 1'b1;

    salc_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_in_valid, .o_in_ready, .o_out_valid, .i_out_ready,
        .i_stat(stat), .o_ctrl(ctrl)
    );

    salc_datapath #(
        .MAX_SET_BITS(MAX_SET_BITS), .MAX_WAYS(MAX_WAYS), .ADDR_WIDTH(ADDR_WIDTH)
    ) u_dp (
        .i_clk, .i_rst_n, .i_cfg_valid, .i_cfg_index, .i_cfg_data,
        .i_in(i_in_word), .i_ctrl(ctrl), .o_stat(stat), .o_out(o_out_word)
    );
endmodule

// File: sv/salc_ctrl.sv
// Sequencing state machine for the cache tag store.
module salc_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    input  salc_pkg::t_stat       i_stat,
    output salc_pkg::t_ctrl       o_ctrl
);
    salc_pkg::t_state r_state, n_state;
    logic r_out_valid, n_out_valid;
    logic out_free;

    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            salc_pkg::ST_CLEAR: if (i_stat.clear_last) n_state = salc_pkg::ST_IDLE;
            salc_pkg::ST_IDLE:  if (i_in_valid) n_state = salc_pkg::ST_READ;
            salc_pkg::ST_READ:  n_state = salc_pkg::ST_LOOK1;
            salc_pkg::ST_LOOK1: n_state = i_stat.modify ? salc_pkg::ST_LOOK2
                                                        : salc_pkg::ST_OUT;
            salc_pkg::ST_LOOK2: n_state = salc_pkg::ST_OUT;
            salc_pkg::ST_OUT:   if (out_free) n_state = salc_pkg::ST_IDLE;
            default:            n_state = salc_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_ctrl      = '0;
        o_in_ready  = 1'b0;
        n_out_valid = r_out_valid && !i_out_ready;
        case (r_state)
            salc_pkg::ST_CLEAR: o_ctrl.clear = 1'b1;
            salc_pkg::ST_IDLE: begin
                o_in_ready     = 1'b1;
                o_ctrl.load_in = i_in_valid;
            end
            salc_pkg::ST_READ:  ;
            salc_pkg::ST_LOOK1: o_ctrl.access = 1'b1;
            salc_pkg::ST_LOOK2: o_ctrl.second = 1'b1;
            salc_pkg::ST_OUT: begin
                if (out_free) begin
                    o_ctrl.load_out = 1'b1;
                    n_out_valid     = 1'b1;
                end
            end
            default: ;
        endcase
    end

    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= salc_pkg::ST_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end
endmodule

// File: sv/salc_datapath.sv
// Generic registered-read RAM and the tag-store datapath with ranks, counters and config.
module salc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

module salc_datapath #(
    parameter int MAX_SET_BITS = salc_pkg::MAX_SET_BITS,
    parameter int MAX_WAYS     = salc_pkg::MAX_WAYS,
    parameter int ADDR_WIDTH   = salc_pkg::ADDR_WIDTH
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    input  logic [1:0]           i_cfg_index,
    input  logic [5:0]           i_cfg_data,
    input  salc_pkg::t_in_word   i_in,
    input  salc_pkg::t_ctrl      i_ctrl,
    output salc_pkg::t_stat      o_stat,
    output salc_pkg::t_out_word  o_out
);
    localparam int NSETS = 1 << MAX_SET_BITS;
    localparam int WB    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int RB    = WB;
    localparam int SB    = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
    localparam int WCW   = $clog2(MAX_WAYS + 1);
    localparam int EW    = 1 + RB + ADDR_WIDTH;
    localparam int RW    = MAX_WAYS * EW;
    localparam logic [RB-1:0] RMAX = RB'(MAX_WAYS - 1);

    logic [2:0] r_set_bits;
    logic [5:0] r_offset_bits;
    logic [3:0] r_ways;
    logic [1:0] r_mode;
    logic [ADDR_WIDTH-1:0] r_addr;
    logic [1:0] r_outcome;
    logic r_second;
    logic [31:0] r_hits, r_misses, r_evicts;
    logic [SB-1:0] r_clr_addr;
    salc_pkg::t_out_word r_out;

    // one row per set; each way holds {valid, rank, tag}
    logic [RW-1:0] rd_row, wr_row, ram_wdata;
    logic ram_we;
    logic [SB-1:0] ram_waddr;
    logic [MAX_WAYS-1:0] vld;
    logic [RB-1:0] rnk [MAX_WAYS];
    logic [ADDR_WIDTH-1:0] tg [MAX_WAYS];

    logic [3:0] sb;
    logic [WCW-1:0] ways;
    logic [6:0] tsh;
    logic [ADDR_WIDTH-1:0] shs, sht, tag;
    logic [SB-1:0] set;
    logic [MAX_WAYS-1:0] used, hitv, freev;
    logic hit, any_free;
    logic [WB-1:0] hit_w, free_w, vic_w, sel_w;
    logic [RB-1:0] best, lim;
    logic [1:0] outc;

    salc_ram #(
        .WIDTH(RW), .DEPTH(NSETS)
    ) u_ram (
        .i_clk, .i_we(ram_we), .i_waddr(ram_waddr), .i_wdata(ram_wdata),
        .i_raddr(set), .o_rdata(rd_row)
    );

    always_comb begin
        sb   = ({1'b0, r_set_bits} > 4'(MAX_SET_BITS)) ? 4'(MAX_SET_BITS)
                                                       : {1'b0, r_set_bits};
        ways = (r_ways == 4'd0) ? WCW'(1) :
               ({2'b0, r_ways} > 6'(MAX_WAYS) ? WCW'(MAX_WAYS) : WCW'(r_ways));
        tsh  = {1'b0, r_offset_bits} + {3'b0, sb};
        shs  = ({1'b0, r_offset_bits} >= 7'(ADDR_WIDTH)) ? '0 : r_addr >> r_offset_bits;
        sht  = (tsh >= 7'(ADDR_WIDTH)) ? '0 : r_addr >> tsh;
        set  = SB'(shs) & SB'((1 << sb) - 1);
        tag  = sht;
        for (int w = 0; w < MAX_WAYS; w++) begin
            tg[w]    = rd_row[w*EW +: ADDR_WIDTH];
            rnk[w]   = rd_row[w*EW + ADDR_WIDTH +: RB];
            vld[w]   = rd_row[w*EW + ADDR_WIDTH + RB];
            used[w]  = (w < ways);
            hitv[w]  = used[w] && vld[w] && tg[w] == tag;
            freev[w] = used[w] && !vld[w];
        end
        hit = |hitv;
        any_free = |freev;
        hit_w = '0; free_w = '0; vic_w = '0; best = rnk[0];
        for (int w = MAX_WAYS - 1; w >= 0; w--) begin
            if (hitv[w]) hit_w = WB'(w);
            if (freev[w]) free_w = WB'(w);
        end
        for (int w = 1; w < MAX_WAYS; w++) begin
            if (used[w] && rnk[w] > best) begin
                best = rnk[w];
                vic_w = WB'(w);
            end
        end
        if (hit) begin
            sel_w = hit_w; lim = rnk[hit_w]; outc = salc_pkg::OUT_HIT;
        end else if (any_free) begin
            sel_w = free_w; lim = RMAX; outc = salc_pkg::OUT_FILL;
        end else begin
            sel_w = vic_w; lim = best; outc = salc_pkg::OUT_EVICT;
        end
        for (int w = 0; w < MAX_WAYS; w++) begin
            if (WB'(w) == sel_w)
                wr_row[w*EW +: EW] = {1'b1, RB'(0), tag};
            else if (used[w] && vld[w] && rnk[w] < lim)
                wr_row[w*EW +: EW] = {1'b1, rnk[w] + RB'(1), tg[w]};
            else
                wr_row[w*EW +: EW] = rd_row[w*EW +: EW];
        end
    end

    assign ram_we    = i_ctrl.clear || i_ctrl.access;
    assign ram_waddr = i_ctrl.clear ? r_clr_addr : set;
    assign ram_wdata = i_ctrl.clear ? '0 : wr_row;

    assign o_stat.modify     = (r_mode == salc_pkg::MODE_MODIFY);
    assign o_stat.clear_last = (r_clr_addr == SB'(NSETS - 1));
    assign o_out = r_out;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load_in) begin
            r_mode <= i_in.mode;
            r_addr <= i_in.address[ADDR_WIDTH-1:0];
        end
        if (i_ctrl.access) begin
            r_outcome <= outc;
            r_second  <= 1'b0;
        end
        // second access of a modify always hits the line just left at rank 0
        if (i_ctrl.second) r_second <= 1'b1;
        if (i_ctrl.load_out) begin
            r_out.outcome         <= r_outcome;
            r_out.second_hit      <= r_second;
            r_out.hits_total      <= r_hits;
            r_out.misses_total    <= r_misses;
            r_out.evictions_total <= r_evicts;
        end
        if (!i_rst_n) begin
            r_set_bits    <= 3'd4;
            r_offset_bits <= 6'd4;
            r_ways        <= 4'd1;
            r_hits <= '0; r_misses <= '0; r_evicts <= '0;
            r_clr_addr    <= '0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    salc_pkg::CFG_SET_BITS:    r_set_bits    <= i_cfg_data[2:0];
                    salc_pkg::CFG_OFFSET_BITS: r_offset_bits <= i_cfg_data;
                    salc_pkg::CFG_WAYS_IN_USE: r_ways        <= i_cfg_data[3:0];
                    default: ;
                endcase
            end
            if (i_ctrl.clear) r_clr_addr <= r_clr_addr + 1'b1;
            if (i_ctrl.access) begin
                if (hit && r_hits != '1) r_hits <= r_hits + 1'b1;
                if (!hit && r_misses != '1) r_misses <= r_misses + 1'b1;
                if (!hit && !any_free && r_evicts != '1) r_evicts <= r_evicts + 1'b1;
            end
            if (i_ctrl.second && r_hits != '1) r_hits <= r_hits + 1'b1;
        end
    end
endmodule

// File: sv/salc_checker.sv
// Port-level checks for the cache tag store, bound to the top level.
`include "set_assoc_lru_cache_model_core_defines.svh"
module salc_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_ready,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input salc_pkg::t_out_word o_out_word
);
    `SALC_ASSERT_NEXT(a_one_in_flight, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready, "ready after accept")
    `SALC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_word), "stalled word dropped or changed")
    `SALC_ASSERT_IMPL(a_outcome_legal, i_clk, i_rst_n, o_out_valid, o_out_word.outcome <= salc_pkg::OUT_EVICT, "bad outcome")
    `SALC_ASSERT_IMPL(a_evict_le_miss, i_clk, i_rst_n, o_out_valid, o_out_word.evictions_total <= o_out_word.misses_total, "evictions exceed misses")
endmodule

bind set_assoc_lru_cache_model_core salc_checker u_salc_checker (
    .i_clk, .i_rst_n, .i_in_valid, .o_in_ready, .o_out_valid, .i_out_ready, .o_out_word
);

// File: bench/set_assoc_lru_cache_model_core_tb.sv
// Testbench for the set-associative LRU cache tag store: random and directed words, checked against a local predictor.
`timescale 1ns / 1ps

module set_assoc_lru_cache_model_core_tb;
    import salc_pkg::*;

    localparam logic [1:0] MODE_RESERVED = 2'd3;
    localparam int NSETS = 1 << MAX_SET_BITS;
    localparam int NLINES = NSETS * MAX_WAYS;
    localparam int LIMIT = 400000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [5:0]  i_cfg_data;
    logic        i_in_valid;
    logic        o_in_ready;
    t_in_word    i_in_word;
    logic        o_out_valid;
    logic        i_out_ready;
    t_out_word   o_out_word;

    set_assoc_lru_cache_model_core uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in_word(i_in_word),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out_word(o_out_word)
    );

    // predictor state
    logic        tag_valid [NLINES];
    logic [63:0] tag_store [NLINES];
    logic [2:0]  age_rank  [NLINES];
    logic [31:0] n_hits, n_misses, n_evicts;
    logic [2:0]  cur_set_bits;
    logic [5:0]  cur_offset_bits;
    logic [3:0]  cur_ways;

    t_in_word    pending_words[$];
    t_out_word   expected_words[$];
    logic [63:0] addr_pool [16];
    int          cycle_count;
    int          errors;
    logic        calm;

    function automatic logic [63:0] shift_down(logic [63:0] x, int n);
        return (n >= 64) ? 64'd0 : (x >> n);
    endfunction

    function automatic logic [31:0] sat_inc(logic [31:0] v);
        return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
    endfunction

    function automatic void age_set(int base, int ways, int lim);
        for (int w = 0; w < ways; w++) begin
            if (tag_valid[base + w] && age_rank[base + w] < lim &&
                age_rank[base + w] < MAX_WAYS - 1)
                age_rank[base + w] = age_rank[base + w] + 3'd1;
        end
    endfunction

    function automatic logic [1:0] cache_access(logic [63:0] addr);
        int sb, ways, base, victim, best;
        logic [63:0] a, tag;
        logic [63:0] set_idx;
        sb = (cur_set_bits > MAX_SET_BITS) ? MAX_SET_BITS : cur_set_bits;
        ways = (cur_ways == 0) ? 1 : ((cur_ways > MAX_WAYS) ? MAX_WAYS : cur_ways);
        a = addr;
        set_idx = shift_down(a, cur_offset_bits) & ((64'd1 << sb) - 64'd1);
        tag = shift_down(a, cur_offset_bits + sb);
        base = int'(set_idx) * MAX_WAYS;
        for (int w = 0; w < ways; w++) begin
            if (tag_valid[base + w] && tag_store[base + w] == tag) begin
                age_set(base, ways, age_rank[base + w]);
                age_rank[base + w] = 3'd0;
                n_hits = sat_inc(n_hits);
                return OUT_HIT;
            end
        end
        n_misses = sat_inc(n_misses);
        for (int w = 0; w < ways; w++) begin
            if (!tag_valid[base + w]) begin
                age_set(base, ways, MAX_WAYS);
                tag_valid[base + w] = 1'b1;
                tag_store[base + w] = tag;
                age_rank[base + w] = 3'd0;
                return OUT_FILL;
            end
        end
        n_evicts = sat_inc(n_evicts);
        victim = 0;
        best = age_rank[base];
        for (int w = 1; w < ways; w++) begin
            if (age_rank[base + w] > best) begin
                best = age_rank[base + w];
                victim = w;
            end
        end
        age_set(base, ways, best);
        tag_store[base + victim] = tag;
        age_rank[base + victim] = 3'd0;
        return OUT_EVICT;
    endfunction

    function automatic t_out_word predict_lookup(t_in_word wd);
        t_out_word r;
        r.outcome = cache_access(wd.address);
        r.second_hit = 1'b0;
        if (wd.mode == MODE_MODIFY)
            r.second_hit = (cache_access(wd.address) == OUT_HIT);
        r.hits_total = n_hits;
        r.misses_total = n_misses;
        r.evictions_total = n_evicts;
        return r;
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        calm <= (cycle_count >= 2000 && cycle_count < 3500);
        if (cycle_count >= LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // input driver; prediction happens on acceptance
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready)
                expected_words.push_back(predict_lookup(i_in_word));
            if (!i_in_valid || o_in_ready) begin
                if (pending_words.size() > 0 && (calm || $urandom_range(99) >= 31)) begin
                    i_in_word <= pending_words.pop_front();
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // output monitor
    always @(posedge i_clk) begin
        i_out_ready <= calm || ($urandom_range(99) >= 31);
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_words.size() == 0) begin
                $display("%0t: unexpected word %h", $time, o_out_word);
                errors <= errors + 1;
            end else begin
                t_out_word e;
                e = expected_words.pop_front();
                if (e.outcome !== o_out_word.outcome)
                    $display("%0t: outcome exp %0d got %0d", $time, e.outcome,
                             o_out_word.outcome);
                if (e.second_hit !== o_out_word.second_hit)
                    $display("%0t: second_hit exp %0d got %0d", $time, e.second_hit,
                             o_out_word.second_hit);
                if (e.hits_total !== o_out_word.hits_total)
                    $display("%0t: hits_total exp %0d got %0d", $time, e.hits_total,
                             o_out_word.hits_total);
                if (e.misses_total !== o_out_word.misses_total)
                    $display("%0t: misses_total exp %0d got %0d", $time, e.misses_total,
                             o_out_word.misses_total);
                if (e.evictions_total !== o_out_word.evictions_total)
                    $display("%0t: evictions_total exp %0d got %0d", $time,
                             e.evictions_total, o_out_word.evictions_total);
                if (e !== o_out_word)
                    errors <= errors + 1;
            end
        end
    end

    task automatic wait_idle();
        @(posedge i_clk);
        while (pending_words.size() != 0 || i_in_valid || expected_words.size() != 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [1:0] idx, logic [5:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            CFG_SET_BITS:    cur_set_bits = val[2:0];
            CFG_OFFSET_BITS: cur_offset_bits = val;
            CFG_WAYS_IN_USE: cur_ways = val[3:0];
            default: ;
        endcase
        i_cfg_valid <= 1'b0;
    endtask

    task automatic push_word(logic [1:0] m, logic [63:0] a);
        t_in_word wd;
        wd.mode = m;
        wd.address = a;
        pending_words.push_back(wd);
    endtask

    task automatic run_random(int count);
        logic [63:0] a;
        for (int k = 0; k < 16; k++) addr_pool[k] = {$urandom, $urandom};
        for (int k = 0; k < count; k++) begin
            if ($urandom_range(99) < 80)
                a = addr_pool[$urandom_range(15)] ^ {58'd0, 6'($urandom)};
            else
                a = {$urandom, $urandom};
            push_word(2'($urandom_range(3)), a);
        end
        wait_idle();
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_SET_BITS;
        i_cfg_data = 6'd0;
        i_in_valid = 1'b0;
        i_in_word = '0;
        i_out_ready = 1'b0;
        cycle_count = 0;
        errors = 0;
        calm = 1'b0;
        n_hits = 0;
        n_misses = 0;
        n_evicts = 0;
        cur_set_bits = 3'd4;
        cur_offset_bits = 6'd4;
        cur_ways = 4'd1;
        for (int k = 0; k < NLINES; k++) begin
            tag_valid[k] = 1'b0;
            tag_store[k] = '0;
            age_rank[k] = '0;
        end
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (4) @(posedge i_clk);

        // directed part at the reset settings
        push_word(MODE_LOAD, 64'd0);
        push_word(MODE_LOAD, 64'd0);
        push_word(MODE_STORE, 64'hFFFF_FFFF_FFFF_FFFF);
        push_word(MODE_MODIFY, 64'hFFFF_FFFF_FFFF_FFFF);
        push_word(MODE_MODIFY, 64'h1234_5678_9ABC_DEF0);
        push_word(MODE_RESERVED, 64'h1234_5678_9ABC_DEF0);
        push_word(MODE_RESERVED, 64'h8000_0000_0000_0000);
        push_word(MODE_STORE, 64'h0000_0000_0000_0100);
        push_word(MODE_LOAD, 64'h5555_5555_5555_5555);
        push_word(MODE_LOAD, 64'hAAAA_AAAA_AAAA_AAAA);
        wait_idle();
        // eight ways, two sets: fill, hit and evict
        cfg_write(CFG_WAYS_IN_USE, 6'd8);
        cfg_write(CFG_SET_BITS, 3'd1);
        cfg_write(CFG_OFFSET_BITS, 6'd0);
        for (int k = 0; k < 10; k++) push_word(MODE_LOAD, 64'(k * 2) << 1);
        push_word(MODE_MODIFY, 64'd4);
        push_word(MODE_LOAD, 64'd0);
        wait_idle();
        // reconfiguration keeps lines; fewer ways in use
        cfg_write(CFG_WAYS_IN_USE, 6'd2);
        run_random(60);

        cfg_write(CFG_SET_BITS, 6'd0);
        cfg_write(CFG_OFFSET_BITS, 6'd0);
        cfg_write(CFG_WAYS_IN_USE, 6'd1);
        run_random(60);

        cfg_write(CFG_SET_BITS, 6'd7);
        cfg_write(CFG_OFFSET_BITS, 6'd63);
        cfg_write(CFG_WAYS_IN_USE, 6'd15);
        run_random(50);

        cfg_write(CFG_SET_BITS, 6'd6);
        cfg_write(CFG_OFFSET_BITS, 6'd60);
        cfg_write(CFG_WAYS_IN_USE, 6'd0);
        run_random(50);

        cfg_write(CFG_SET_BITS, 6'd6);
        cfg_write(CFG_OFFSET_BITS, 6'd32);
        cfg_write(CFG_WAYS_IN_USE, 6'd8);
        run_random(80);

        cfg_write(CFG_SET_BITS, 6'd2);
        cfg_write(CFG_OFFSET_BITS, 6'd1);
        cfg_write(CFG_WAYS_IN_USE, 6'd4);
        run_random(100);

        cfg_write(CFG_SET_BITS, 6'd0);
        cfg_write(CFG_OFFSET_BITS, 6'd5);
        cfg_write(CFG_WAYS_IN_USE, 6'd3);
        run_random(100);

        cfg_write(CFG_SET_BITS, 6'd1);
        cfg_write(CFG_OFFSET_BITS, 6'd58);
        cfg_write(CFG_WAYS_IN_USE, 6'd8);
        run_random(100);

        repeat (20) @(posedge i_clk);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule
